// ===== sv/dtsp_pkg.sv =====
`timescale 1ns / 1ps
package dtsp_pkg;

	localparam int CharW = 8;
	localparam int YearW = 16;
	localparam int OutW = 48;
	localparam logic [YearW-1:0] MinYear = 16'd1900;
	localparam logic [YearW-1:0] ResetYear = 16'd2024;
	localparam logic [YearW-1:0] Inv25 = 16'd23593;
	localparam logic [YearW-1:0] Div25Max = 16'd2621;
	localparam logic [CharW-1:0] ChZero = 8'h30;
	localparam logic [CharW-1:0] ChNine = 8'h39;
	localparam logic [CharW-1:0] ChDot = 8'h2e;
	localparam logic [CharW-1:0] ChDash = 8'h2d;
	localparam logic [CharW-1:0] ChColon = 8'h3a;

	typedef enum logic [1:0] {
		ST_COMPLETE = 2'd0,
		ST_PARTIAL  = 2'd1,
		ST_INVALID  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		F_YEAR   = 3'd0,
		F_MONTH  = 3'd1,
		F_DAY    = 3'd2,
		F_HOUR   = 3'd3,
		F_MINUTE = 3'd4
	} field_t;

	typedef struct packed {
		logic [CharW-1:0] char_code;
		logic             has_char;
		logic             is_last;
	} item_t;

	typedef struct packed {
		logic [5:0]       minute;
		logic [4:0]       hour;
		logic [4:0]       day;
		logic [3:0]       month;
		logic [YearW-1:0] year;
		logic [4:0]       present_mask;
		status_t          status;
	} res_t;

	function automatic logic is_leap(input logic [YearW-1:0] y);
		logic [2*YearW-1:0] prod;
		logic               div25;
		logic               leap;
		prod = {{YearW{1'b0}}, y} * {{YearW{1'b0}}, Inv25};
		div25 = (prod[YearW-1:0] <= Div25Max);
		if (y[3:0] == 4'd0 && div25) begin
			leap = 1'b1;
		end else if (y[1:0] == 2'd0 && div25) begin
			leap = 1'b0;
		end else begin
			leap = (y[1:0] == 2'd0);
		end
		return leap;
	endfunction

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic [YearW-1:0] y);
		logic [4:0] n;
		case (m)
			4'd2: begin
				n = is_leap(y) ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				n = 5'd30;
			end
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
				n = 5'd31;
			end
			default: begin
				n = 5'd0;
			end
		endcase
		return n;
	endfunction

	function automatic logic [CharW-1:0] sep_after(input field_t f);
		logic [CharW-1:0] s;
		case (f)
			F_YEAR:  s = ChDot;
			F_MONTH: s = ChDot;
			F_DAY:   s = ChDash;
			F_HOUR:  s = ChColon;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/dtsp_core.sv =====
`timescale 1ns / 1ps
module dtsp_core (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  dtsp_pkg::item_t          item,
	input  logic [15:0]              cur_year,
	output dtsp_pkg::res_t           res
);
	import dtsp_pkg::*;

	field_t       fi_q;
	logic         need_q;
	logic [63:0]  acc_q;
	logic         ovf_q;
	logic [15:0]  held_year_q;
	logic [3:0]   held_month_q;
	logic [4:0]   held_day_q;
	logic [4:0]   held_hour_q;
	logic         failed_q;

	field_t       fi_d;
	logic         need_d;
	logic [63:0]  acc_d;
	logic         ovf_d;
	logic [15:0]  held_year_d;
	logic [3:0]   held_month_d;
	logic [4:0]   held_day_d;
	logic [4:0]   held_hour_d;
	logic         failed_d;

	logic         take;
	logic         is_digit;
	logic [66:0]  wide;
	logic         wide_ovf;
	logic [63:0]  chk_acc;
	logic         chk_ovf;
	logic [15:0]  v16;
	logic [7:0]   v8;
	logic         close_pass;
	logic         invalid;

	assign take = item.has_char && !failed_q;
	assign is_digit = (item.char_code >= ChZero) && (item.char_code <= ChNine);
	assign wide = ({3'b000, acc_q} << 3) + ({3'b000, acc_q} << 1)
		+ {63'd0, 4'(item.char_code - ChZero)};
	assign wide_ovf = (wide[66:63] != 4'd0);

	// The open field is checked on its value after this character.
	always_comb begin
		chk_acc = acc_q;
		chk_ovf = ovf_q;
		if (take && is_digit && !ovf_q) begin
			if (wide_ovf) begin
				chk_ovf = 1'b1;
			end else begin
				chk_acc = wide[63:0];
			end
		end
	end

	assign v16 = chk_acc[15:0];
	assign v8 = chk_acc[7:0];

	always_comb begin
		close_pass = 1'b0;
		case (fi_q)
			F_YEAR: begin
				close_pass = (v16 >= MinYear) && (v16 <= cur_year);
			end
			F_MONTH: begin
				close_pass = (v8 >= 8'd1) && (v8 <= 8'd12);
			end
			F_DAY: begin
				close_pass = (v8 >= 8'd1)
					&& (v8 <= {3'b000, month_days(held_month_q, held_year_q)});
			end
			F_HOUR: begin
				close_pass = (v8 <= 8'd23);
			end
			default: begin
				close_pass = (v8 <= 8'd59);
			end
		endcase
		if (chk_ovf) begin
			close_pass = 1'b0;
		end
	end

	always_comb begin
		fi_d = fi_q;
		need_d = need_q;
		acc_d = chk_acc;
		ovf_d = chk_ovf;
		held_year_d = held_year_q;
		held_month_d = held_month_q;
		held_day_d = held_day_q;
		held_hour_d = held_hour_q;
		failed_d = failed_q;
		if (take) begin
			if (is_digit) begin
				need_d = 1'b0;
			end else if (!need_q && fi_q != F_MINUTE && item.char_code == sep_after(fi_q)
				&& close_pass) begin
				case (fi_q)
					F_YEAR:  held_year_d = v16;
					F_MONTH: held_month_d = v8[3:0];
					F_DAY:   held_day_d = v8[4:0];
					default: held_hour_d = v8[4:0];
				endcase
				fi_d = field_t'(fi_q + 3'd1);
				need_d = 1'b1;
				acc_d = 64'd0;
				ovf_d = 1'b0;
			end else begin
				failed_d = 1'b1;
			end
		end
	end

	assign invalid = failed_d || need_d || !close_pass;

	always_comb begin
		res = '0;
		res.status = ST_INVALID;
		if (!invalid) begin
			res.status = (fi_q == F_MINUTE) ? ST_COMPLETE : ST_PARTIAL;
			res.present_mask = 5'((6'd2 << fi_q) - 6'd1);
			res.year = (fi_q == F_YEAR) ? v16 : held_year_q;
			if (fi_q == F_MONTH) begin
				res.month = v8[3:0];
			end else if (fi_q > F_MONTH) begin
				res.month = held_month_q;
			end
			if (fi_q == F_DAY) begin
				res.day = v8[4:0];
			end else if (fi_q > F_DAY) begin
				res.day = held_day_q;
			end
			if (fi_q == F_HOUR) begin
				res.hour = v8[4:0];
			end else if (fi_q > F_HOUR) begin
				res.hour = held_hour_q;
			end
			if (fi_q == F_MINUTE) begin
				res.minute = v8[5:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fi_q <= F_YEAR;
			need_q <= 1'b1;
			acc_q <= 64'd0;
			ovf_q <= 1'b0;
			held_year_q <= 16'd0;
			held_month_q <= 4'd0;
			held_day_q <= 5'd0;
			held_hour_q <= 5'd0;
			failed_q <= 1'b0;
		end else if (step) begin
			if (item.is_last) begin
				fi_q <= F_YEAR;
				need_q <= 1'b1;
				acc_q <= 64'd0;
				ovf_q <= 1'b0;
				held_year_q <= 16'd0;
				held_month_q <= 4'd0;
				held_day_q <= 5'd0;
				held_hour_q <= 5'd0;
				failed_q <= 1'b0;
			end else begin
				fi_q <= fi_d;
				need_q <= need_d;
				acc_q <= acc_d;
				ovf_q <= ovf_d;
				held_year_q <= held_year_d;
				held_month_q <= held_month_d;
				held_day_q <= held_day_d;
				held_hour_q <= held_hour_d;
				failed_q <= failed_d;
			end
		end
	end

endmodule

// ===== sv/date_time_string_parser.sv =====
// A character taken from s_axis is held in the input register; the last one
// of a string waits there until the result register is free, then loads it.
// Throughput: one character per cycle, set by the input register and the
// single parse step between it and the result register, but for that wait.
// Reset: arst_n clears the parse state, both valid flags and sets the
// current year limit to 2024.
`timescale 1ns / 1ps
module date_time_string_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // char_code
	input  logic        s_axis_tuser,  // has_char
	input  logic        s_axis_tlast,  // is_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status, present_mask, year, month, day, hour, minute, zero pad
	output logic [47:0] m_axis_tdata
);
	import dtsp_pkg::*;

	logic [15:0] cur_year_q;
	logic        valid_s1;
	item_t       item_s1;
	logic        advance;
	res_t        res;
	res_t        res_q;
	logic        res_valid_q;

	assign advance = valid_s1 && (!item_s1.is_last || !res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q <= ResetYear;
		end else if (cfg_we) begin
			cur_year_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= '{char_code: s_axis_tdata, has_char: s_axis_tuser,
				is_last: s_axis_tlast};
		end
	end

	dtsp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.cur_year (cur_year_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && item_s1.is_last) begin
			res_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.is_last) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata = {{(OutW - $bits(res_t)){1'b0}}, res_q};

endmodule

// ===== sv/dtsp_checker.sv =====
`timescale 1ns / 1ps
module dtsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);
	import dtsp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == ST_INVALID |-> m_axis_tdata[47:2] == 46'd0)
		else $error("invalid result carries field data");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[47:43] == 5'd0)
		else $error("bad status code or pad bits");

	a_complete_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == ST_COMPLETE |-> m_axis_tdata[6:2] == 5'h1f)
		else $error("complete result lacks a field");

	a_partial_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == ST_PARTIAL
		|-> m_axis_tdata[2] && m_axis_tdata[6] == 1'b0)
		else $error("partial result has a bad field mask");

endmodule

bind date_time_string_parser dtsp_checker u_dtsp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
	import dtsp_pkg::*;

	typedef logic [7:0] text_t[$];

	localparam int WatchdogLimit = 2000;
	localparam int PhaseItems = 430;
	localparam int MaxReports = 10;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;

	date_time_string_parser u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	int   idle_pct;
	int   stall_pct;
	int   items_sent;
	int   n_errors;
	int   quiet_cycles;
	res_t expected_dates[$];

	logic [15:0] year_limit;
	field_t      fld;
	logic        need_dig;
	logic [63:0] acc;
	logic        acc_ovf;
	logic [15:0] p_year;
	logic [3:0]  p_month;
	logic [4:0]  p_day;
	logic [4:0]  p_hour;
	logic        failed;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
		int unsigned n;
		case (m)
			2: begin
				n = ((y % 400 == 0) || (y % 100 != 0 && y % 4 == 0)) ? 29 : 28;
			end
			4, 6, 9, 11: begin
				n = 30;
			end
			1, 3, 5, 7, 8, 10, 12: begin
				n = 31;
			end
			default: begin
				n = 0;
			end
		endcase
		return n;
	endfunction

	function automatic void clear_date();
		fld = F_YEAR;
		need_dig = 1'b1;
		acc = '0;
		acc_ovf = 1'b0;
		p_year = '0;
		p_month = '0;
		p_day = '0;
		p_hour = '0;
		failed = 1'b0;
	endfunction

	// Checks the open field and, when it passes, keeps a year, month, day or hour.
	function automatic bit field_closes();
		logic [15:0] v16;
		logic [7:0]  v8;
		v16 = acc[15:0];
		v8 = acc[7:0];
		if (acc_ovf) begin
			return 1'b0;
		end
		case (fld)
			F_YEAR: begin
				if (v16 < MinYear || v16 > year_limit) begin
					return 1'b0;
				end
				p_year = v16;
			end
			F_MONTH: begin
				if (v8 < 1 || v8 > 12) begin
					return 1'b0;
				end
				p_month = v8[3:0];
			end
			F_DAY: begin
				if (v8 < 1 || v8 > month_length(p_month, p_year)) begin
					return 1'b0;
				end
				p_day = v8[4:0];
			end
			F_HOUR: begin
				if (v8 > 23) begin
					return 1'b0;
				end
				p_hour = v8[4:0];
			end
			default: begin
				return v8 <= 59;
			end
		endcase
		return 1'b1;
	endfunction

	function automatic void track_char(input logic [7:0] c, input logic has, input logic last);
		logic [63:0] d;
		logic [7:0]  sep;
		res_t        r;
		case (fld)
			F_YEAR, F_MONTH: sep = ChDot;
			F_DAY:           sep = ChDash;
			F_HOUR:          sep = ChColon;
			default:         sep = 8'h00;
		endcase
		if (has && !failed) begin
			if (c >= ChZero && c <= ChNine) begin
				d = 64'(c - ChZero);
				if (!acc_ovf) begin
					if (acc > (64'h7FFF_FFFF_FFFF_FFFF - d) / 64'd10) begin
						acc_ovf = 1'b1;
					end else begin
						acc = acc * 64'd10 + d;
					end
				end
				need_dig = 1'b0;
			end else if (need_dig || fld == F_MINUTE || c != sep || !field_closes()) begin
				failed = 1'b1;
			end else begin
				fld = field_t'(fld + 3'd1);
				need_dig = 1'b1;
				acc = '0;
				acc_ovf = 1'b0;
			end
		end
		if (last) begin
			r = '0;
			if (failed || need_dig || !field_closes()) begin
				r.status = ST_INVALID;
			end else begin
				r.status = (fld == F_MINUTE) ? ST_COMPLETE : ST_PARTIAL;
				r.present_mask = 5'((32'd1 << (int'(fld) + 1)) - 1);
				r.year = p_year;
				if (fld >= F_MONTH) begin
					r.month = p_month;
				end
				if (fld >= F_DAY) begin
					r.day = p_day;
				end
				if (fld >= F_HOUR) begin
					r.hour = p_hour;
				end
				if (fld == F_MINUTE) begin
					r.minute = acc[5:0];
				end
			end
			expected_dates.push_back(r);
			clear_date();
		end
	endfunction

	function automatic string show_date(input res_t r);
		return $sformatf("status=%0d mask=%b %0d.%0d.%0d-%0d:%0d", r.status, r.present_mask,
			r.year, r.month, r.day, r.hour, r.minute);
	endfunction

	function automatic text_t to_text(input string s);
		text_t q;
		for (int i = 0; i < s.len(); i++) begin
			q.push_back(s[i]);
		end
		return q;
	endfunction

	function automatic logic [7:0] stray_char();
		logic [7:0] c;
		case ($urandom_range(3))
			0:       c = ChDot;
			1:       c = ChDash;
			2:       c = ChColon;
			default: c = 8'($urandom_range(255));
		endcase
		return c;
	endfunction

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : check_results
		res_t got;
		res_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata[42:0]);
			if (expected_dates.size() == 0) begin
				n_errors++;
				if (n_errors <= MaxReports) begin
					$display("Unexpected result: %s", show_date(got));
				end
			end else begin
				want = expected_dates.pop_front();
				if (got.status !== want.status || got.present_mask !== want.present_mask ||
						got.year !== want.year || got.month !== want.month ||
						got.day !== want.day || got.hour !== want.hour ||
						got.minute !== want.minute) begin
					n_errors++;
					if (n_errors <= MaxReports) begin
						$display("Mismatch: expected %s, actual %s", show_date(want),
							show_date(got));
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WatchdogLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_item(input logic [7:0] c, input logic has, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tuser <= has;
		s_axis_tlast <= last;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		track_char(c, has, last);
		if (has || last) begin
			items_sent++;
		end
	endtask

	task automatic send_text(input text_t text, input bit apart, input int noise);
		for (int i = 0; i < text.size(); i++) begin
			if ($urandom_range(99) < noise) begin
				send_item(8'($urandom_range(255)), 1'b0, 1'b0);
			end
			send_item(text[i], 1'b1, !apart && i == text.size() - 1);
		end
		if (apart || text.size() == 0) begin
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
		end
	endtask

	task automatic wait_for_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_dates.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_year_limit(input logic [15:0] v);
		wait_for_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		year_limit = v;
	endtask

	task automatic append_number(ref text_t q, input int unsigned v);
		string s;
		int    pick;
		pick = $urandom_range(199);
		if (pick == 0) begin
			s = "9223372036854775807";
		end else if (pick == 1) begin
			s = "9223372036854775808";
		end else if (pick == 2) begin
			s = "";
			repeat ($urandom_range(25, 19)) s = {s, $sformatf("%0d", $urandom_range(9))};
		end else begin
			s = $sformatf("%0d", v);
			if ($urandom_range(9) == 0) begin
				s = {"0", s};
			end
		end
		for (int i = 0; i < s.len(); i++) begin
			q.push_back(s[i]);
		end
	endtask

	task automatic build_date_text(ref text_t q);
		int unsigned y;
		int unsigned mo;
		int unsigned d;
		int unsigned h;
		int unsigned mi;
		int unsigned maxd;
		int unsigned nf;
		int unsigned pick;
		q.delete();
		pick = $urandom_range(99);
		if (pick < 3) begin
			return;
		end
		if (pick < 7) begin
			repeat ($urandom_range(6, 1)) q.push_back(8'($urandom_range(255)));
			return;
		end
		nf = ($urandom_range(99) < 65) ? 5 : $urandom_range(4, 1);
		case ($urandom_range(19))
			0:       y = $urandom_range(MinYear - 1, 0);
			1:       y = year_limit + 1 + $urandom_range(9);
			2:       y = year_limit;
			3:       y = MinYear;
			4:       y = (year_limit >= 2000) ? 2000 : MinYear;
			5:       y = 65536 * $urandom_range(3, 1) + $urandom_range(year_limit, MinYear);
			default: y = $urandom_range(year_limit, MinYear);
		endcase
		case ($urandom_range(19))
			0:       mo = 0;
			1:       mo = 13 + $urandom_range(242);
			2:       mo = 256 + $urandom_range(12, 1);
			3:       mo = 2;
			default: mo = $urandom_range(12, 1);
		endcase
		maxd = month_length(mo % 256, y % 65536);
		if (maxd == 0) begin
			maxd = 31;
		end
		case ($urandom_range(9))
			0:       d = 0;
			1:       d = maxd + 1;
			2, 3:    d = maxd;
			default: d = $urandom_range(maxd, 1);
		endcase
		case ($urandom_range(11))
			0:       h = 24 + $urandom_range(231);
			1:       h = 0;
			2:       h = 23;
			default: h = $urandom_range(23);
		endcase
		case ($urandom_range(11))
			0:       mi = 60 + $urandom_range(195);
			1:       mi = 59;
			default: mi = $urandom_range(59);
		endcase
		append_number(q, y);
		if (nf > 1) begin
			q.push_back(ChDot);
			append_number(q, mo);
		end
		if (nf > 2) begin
			q.push_back(ChDot);
			append_number(q, d);
		end
		if (nf > 3) begin
			q.push_back(ChDash);
			append_number(q, h);
		end
		if (nf > 4) begin
			q.push_back(ChColon);
			append_number(q, mi);
		end
		if ($urandom_range(99) < 15) begin
			pick = $urandom_range(q.size() - 1);
			case ($urandom_range(4))
				0:       q.push_back(stray_char());
				1:       q[pick] = stray_char();
				2:       q.delete(pick);
				3:       q.insert($urandom_range(q.size()), stray_char());
				default: q[pick] = 8'h00;
			endcase
		end
	endtask

	task automatic test_directed_cases();
		text_t q;
		idle_pct = 0;
		stall_pct = 0;
		q.delete();
		send_text(q, 1'b1, 0);
		send_item(8'hFF, 1'b0, 1'b0);
		send_text(to_text("2024.2.29-0:0"), 1'b0, 0);
		send_text(to_text("1900"), 1'b1, 0);
		send_text(to_text("."), 1'b0, 0);
		q = to_text("1999");
		q.push_back(8'h00);
		send_text(q, 1'b0, 0);
	endtask

	task automatic test_year_limit_edges();
		write_year_limit(MinYear);
		send_text(to_text("1901"), 1'b0, 0);
		send_text(to_text("1900.1"), 1'b0, 0);
		write_year_limit(16'hFFFF);
		send_text(to_text("65535.12"), 1'b0, 0);
		send_text(to_text("131071"), 1'b1, 0);
	endtask

	task automatic test_random_strings(input logic [15:0] limit, input int idle, input int stall);
		text_t q;
		bit    apart;
		int    stop_at;
		write_year_limit(limit);
		idle_pct = idle;
		stall_pct = stall;
		stop_at = items_sent + PhaseItems;
		while (items_sent < stop_at) begin
			build_date_text(q);
			apart = (q.size() == 0) || ($urandom_range(3) == 0);
			send_text(q, apart, 4);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		n_errors = 0;
		quiet_cycles = 0;
		year_limit = ResetYear;
		clear_date();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_year_limit_edges();
		test_random_strings(16'hFFFF, 0, 0);
		test_random_strings(MinYear, 67, 0);
		test_random_strings(16'($urandom_range(65534, 1901)), 0, 67);
		test_random_strings(ResetYear, 37, 37);
		wait_for_idle();
		repeat (6) @(posedge clk);
		if (n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== date_time_string_parser.f =====
sv/dtsp_pkg.sv
sv/dtsp_core.sv
sv/date_time_string_parser.sv
sv/dtsp_checker.sv
dv/testbench.sv
